[hw/rtl/cpd_pkg.sv]
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, codes and the CRC-8 byte step for the packet deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [6:0] HDR_LEN  = 7'd5;
  localparam logic [6:0] ID_LEN   = 7'd4;
  localparam logic [6:0] POS_MAX  = 7'd127;

  localparam logic KIND_BODY    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_BAD = 2'd1,
    STATUS_SHORT   = 2'd2,
    STATUS_LONG    = 2'd3
  } status_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  body_byte;
    logic [5:0]  body_index;
    logic [31:0] frame_id;
    logic [2:0]  packet_type;
    logic [4:0]  sequence_number;
    logic [6:0]  body_length;
    status_t     frame_status;
  } result_t;

  // MSB-first CRC-8, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

[hw/rtl/cpd_in_stage.sv]
// ----------------------------------------------------------------------------
// cpd_in_stage
// Input register: holds one byte request until the frame core takes it.
// ----------------------------------------------------------------------------
module cpd_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_last
);

  assign in_stall = held_valid & ~take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= data_byte;
      held_last <= last_byte;
    end
  end

endmodule

[hw/rtl/cpd_frame_core.sv]
// ----------------------------------------------------------------------------
// cpd_frame_core
// Frame state (CRC, position, header fields) and per-byte result decode.
// ----------------------------------------------------------------------------
module cpd_frame_core #(
  parameter int MAX_BODY = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            emit,
  output cpd_pkg::result_t result
);

  localparam logic [7:0] MaxBody = 8'(MAX_BODY);

  logic [7:0]  running_crc, running_crc_next;
  logic [6:0]  byte_position, byte_position_next;
  logic [31:0] id_accumulator, id_accumulator_next;
  logic [2:0]  type_register, type_register_next;
  logic [4:0]  sequence_register, sequence_register_next;
  logic        overflow_flag, overflow_flag_next;

  logic [6:0]  body_pos;
  logic        body_full;

  assign body_pos  = byte_position - cpd_pkg::HDR_LEN;
  assign body_full = (byte_position == cpd_pkg::POS_MAX) || ({1'b0, body_pos} >= MaxBody);

  always_comb begin
    running_crc_next       = running_crc;
    byte_position_next     = byte_position;
    id_accumulator_next    = id_accumulator;
    type_register_next     = type_register;
    sequence_register_next = sequence_register;
    overflow_flag_next     = overflow_flag;
    emit                   = 1'b0;
    result                 = '0;

    if (last_byte) begin
      emit                   = 1'b1;
      result.item_kind       = cpd_pkg::KIND_SUMMARY;
      result.frame_id        = id_accumulator;
      result.packet_type     = type_register;
      result.sequence_number = sequence_register;
      if (byte_position < cpd_pkg::HDR_LEN) begin
        result.frame_status = cpd_pkg::STATUS_SHORT;
      end else begin
        result.body_length = ({1'b0, body_pos} > MaxBody) ? MaxBody[6:0] : body_pos;
        if (overflow_flag) begin
          result.frame_status = cpd_pkg::STATUS_LONG;
        end else if (running_crc != data_byte) begin
          result.frame_status = cpd_pkg::STATUS_CRC_BAD;
        end else begin
          result.frame_status = cpd_pkg::STATUS_OK;
        end
      end
      // back to idle-frame state
      running_crc_next       = '0;
      byte_position_next     = '0;
      id_accumulator_next    = '0;
      type_register_next     = '0;
      sequence_register_next = '0;
      overflow_flag_next     = 1'b0;
    end else begin
      running_crc_next = cpd_pkg::crc8_update(running_crc, data_byte);
      if (byte_position != cpd_pkg::POS_MAX) begin
        byte_position_next = byte_position + 7'd1;
      end
      if (byte_position < cpd_pkg::ID_LEN) begin
        id_accumulator_next = {id_accumulator[23:0], data_byte};
      end else if (byte_position == cpd_pkg::ID_LEN) begin
        type_register_next     = data_byte[7:5];
        sequence_register_next = data_byte[4:0];
      end else if (body_full) begin
        overflow_flag_next = 1'b1;
      end else begin
        emit              = 1'b1;
        result.item_kind  = cpd_pkg::KIND_BODY;
        result.body_byte  = data_byte;
        result.body_index = body_pos[5:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc       <= '0;
      byte_position     <= '0;
      id_accumulator    <= '0;
      type_register     <= '0;
      sequence_register <= '0;
      overflow_flag     <= 1'b0;
    end else if (fire) begin
      running_crc       <= running_crc_next;
      byte_position     <= byte_position_next;
      id_accumulator    <= id_accumulator_next;
      type_register     <= type_register_next;
      sequence_register <= sequence_register_next;
      overflow_flag     <= overflow_flag_next;
    end
  end

endmodule

[hw/rtl/cpd_out_stage.sv]
// ----------------------------------------------------------------------------
// cpd_out_stage
// Result register: holds one result request until downstream takes it.
// ----------------------------------------------------------------------------
module cpd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic             emit,
  input  cpd_pkg::result_t result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output cpd_pkg::result_t held
);

  logic out_valid_next;

  assign free = ~out_valid | ~out_stall;

  always_comb begin
    out_valid_next = out_valid;
    if (fire) begin
      out_valid_next = emit;
    end else if (free) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      held <= result;
    end
  end

endmodule

[hw/rtl/crc8_packet_deframer.sv]
// ----------------------------------------------------------------------------
// crc8_packet_deframer
// Byte-stream frame parser: ID/type/sequence header, body bytes out,
// CRC-8 (poly 0x07) check and one summary request per frame.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | data_byte, last_byte
//  out     | output    | out_valid / out_stall| item_kind, body_byte,
//          |           |                      | body_index, frame_id,
//          |           |                      | packet_type, sequence_number,
//          |           |                      | body_length, frame_status
//
// One byte per cycle sustained while out_stall is low; an accepted byte is
// loaded into the input register, then its CRC step and decode are
// registered into the result register.
// Header bytes, overflowed body bytes produce no result request.
// rst (sync, active high) clears the frame state and both valid flags.
// in_stall rises only while the input register is full and the result
// register is held by out_stall.
// ----------------------------------------------------------------------------
module crc8_packet_deframer #(
  parameter int MAX_BODY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        item_kind,
  output logic [7:0]  body_byte,
  output logic [5:0]  body_index,
  output logic [31:0] frame_id,
  output logic [2:0]  packet_type,
  output logic [4:0]  sequence_number,
  output logic [6:0]  body_length,
  output logic [1:0]  frame_status
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             held_last;
  logic             free;
  logic             fire;
  logic             emit;
  cpd_pkg::result_t result;
  cpd_pkg::result_t out_res;

  // a held byte advances whenever the result register can take its outcome
  assign fire = held_valid & free;

  cpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (free),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_last  (held_last)
  );

  cpd_frame_core #(.MAX_BODY(MAX_BODY)) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (held_byte),
    .last_byte (held_last),
    .emit      (emit),
    .result    (result)
  );

  cpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .emit      (emit),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held      (out_res)
  );

  assign item_kind       = out_res.item_kind;
  assign body_byte       = out_res.body_byte;
  assign body_index      = out_res.body_index;
  assign frame_id        = out_res.frame_id;
  assign packet_type     = out_res.packet_type;
  assign sequence_number = out_res.sequence_number;
  assign body_length     = out_res.body_length;
  assign frame_status    = out_res.frame_status;

endmodule

[hw/rtl/cpd_checker.sv]
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks on the deframer result stream.
// ----------------------------------------------------------------------------
module cpd_checker #(
  parameter int MAX_BODY = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        item_kind,
  input logic [7:0]  body_byte,
  input logic [5:0]  body_index,
  input logic [31:0] frame_id,
  input logic [2:0]  packet_type,
  input logic [4:0]  sequence_number,
  input logic [6:0]  body_length,
  input logic [1:0]  frame_status
);

  localparam logic [7:0] MaxBody = 8'(MAX_BODY);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(item_kind) && $stable(body_byte)
      && $stable(body_index) && $stable(frame_id) && $stable(packet_type)
      && $stable(sequence_number) && $stable(body_length) && $stable(frame_status))
    else $error("result changed while stalled");

  a_body_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == cpd_pkg::KIND_BODY |->
      frame_id == '0 && body_length == '0 && frame_status == cpd_pkg::STATUS_OK)
    else $error("body result carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == cpd_pkg::KIND_SUMMARY |-> body_byte == '0 && body_index == '0)
    else $error("summary result carries body fields");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == cpd_pkg::KIND_SUMMARY |->
      {1'b0, body_length} <= MaxBody &&
      (frame_status != cpd_pkg::STATUS_SHORT || body_length == '0))
    else $error("summary body length out of range");

endmodule

bind crc8_packet_deframer cpd_checker #(.MAX_BODY(MAX_BODY)) u_cpd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .item_kind       (item_kind),
  .body_byte       (body_byte),
  .body_index      (body_index),
  .frame_id        (frame_id),
  .packet_type     (packet_type),
  .sequence_number (sequence_number),
  .body_length     (body_length),
  .frame_status    (frame_status)
);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - crc8_packet_deframer
// Drives byte frames (short, nominal, bad CRC, overlong and position-saturating
// bodies) through the deframer with random gaps and output stalls. A local
// frame parser works out the body and summary requests, and the monitor
// checks them field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int BODY_LIMIT  = 64;
  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 10;

  // one input request: a raw byte plus the end-of-frame flag
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        item_kind;
  logic [7:0]  body_byte;
  logic [5:0]  body_index;
  logic [31:0] frame_id;
  logic [2:0]  packet_type;
  logic [4:0]  sequence_number;
  logic [6:0]  body_length;
  logic [1:0]  frame_status;

  byte_req_t        frame_bytes[$];   // requests waiting for the driver
  cpd_pkg::result_t expected_q[$];    // predicted output requests, oldest first
  int          mismatches = 0;
  int          cycles = 0;
  int          in_gap = 0;
  int          out_hold = 0;
  bit          in_burst = 1'b0;  // when set, no idling on that side
  bit          out_burst = 1'b0;

  // parser state mirrored from the block
  logic [7:0]  crc_acc = 8'h00;
  logic [6:0]  pos = 7'd0;
  logic [31:0] id_acc = 32'h0;
  logic [2:0]  ptype = 3'd0;
  logic [4:0]  seqn = 5'd0;
  logic        ovf = 1'b0;

  crc8_packet_deframer #(.MAX_BODY(BODY_LIMIT)) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .last_byte       (last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .item_kind       (item_kind),
    .body_byte       (body_byte),
    .body_index      (body_index),
    .frame_id        (frame_id),
    .packet_type     (packet_type),
    .sequence_number (sequence_number),
    .body_length     (body_length),
    .frame_status    (frame_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bit-serial CRC-8, poly 0x07, MSB first
  function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
    logic [7:0] c;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      if (c[7] ^ d[k]) c = {c[6:0], 1'b0} ^ cpd_pkg::CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Queue one frame. n_hdr + n_body < 5 gives a short frame; fill < 0 means random
  // bytes, otherwise every non-final byte is fill. The final byte is the
  // running CRC, flipped by a random nonzero mask when corrupt is set.
  task automatic add_frame(input int n_hdr, input int n_body, input bit corrupt,
                           input int fill);
    logic [7:0] acc;
    logic [7:0] b;
    byte_req_t  req;
    acc = 8'h00;
    for (int i = 0; i < n_hdr + n_body; i++) begin
      b = (fill < 0) ? 8'($urandom) : 8'(fill);
      acc = crc8_next(acc, b);
      req.data = b;
      req.fin  = 1'b0;
      frame_bytes.push_back(req);
    end
    req.data = corrupt ? (acc ^ 8'($urandom_range(1, 255))) : acc;
    req.fin  = 1'b1;
    frame_bytes.push_back(req);
  endtask

  // Parser step for one accepted byte; pushes the request it causes, if any.
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    cpd_pkg::result_t r;
    int               idx;
    r = '0;
    if (fin) begin
      r.item_kind       = cpd_pkg::KIND_SUMMARY;
      r.frame_id        = id_acc;
      r.packet_type     = ptype;
      r.sequence_number = seqn;
      if (pos < cpd_pkg::HDR_LEN) begin
        r.frame_status = cpd_pkg::STATUS_SHORT;
      end else begin
        idx = int'(pos) - int'(cpd_pkg::HDR_LEN);
        if (idx > BODY_LIMIT) idx = BODY_LIMIT;
        r.body_length = 7'(idx);
        // overflow outranks a bad CRC
        if (ovf) r.frame_status = cpd_pkg::STATUS_LONG;
        else if (crc_acc != b) r.frame_status = cpd_pkg::STATUS_CRC_BAD;
        else r.frame_status = cpd_pkg::STATUS_OK;
      end
      expected_q.push_back(r);
      crc_acc = 8'h00;
      pos     = 7'd0;
      id_acc  = 32'h0;
      ptype   = 3'd0;
      seqn    = 5'd0;
      ovf     = 1'b0;
    end else begin
      crc_acc = crc8_next(crc_acc, b);
      if (pos < cpd_pkg::ID_LEN) begin
        id_acc = {id_acc[23:0], b};
      end else if (pos == cpd_pkg::ID_LEN) begin
        ptype = b[7:5];
        seqn  = b[4:0];
      end else begin
        idx = int'(pos) - int'(cpd_pkg::HDR_LEN);
        // past the body limit or with the position pinned: dropped, flagged
        if (pos >= cpd_pkg::POS_MAX || idx >= BODY_LIMIT) begin
          ovf = 1'b1;
        end else begin
          r.item_kind  = cpd_pkg::KIND_BODY;
          r.body_byte  = b;
          r.body_index = 6'(idx);
          expected_q.push_back(r);
        end
      end
      if (pos < cpd_pkg::POS_MAX) pos = pos + 7'd1;
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // Input driver: records each accepted request in the parser, then offers
  // the next byte or idles for the drawn gap.
  always @(posedge clk) begin
    byte_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_byte(data_byte, last_byte);
      if (!in_valid || !in_stall) begin
        if ($urandom_range(199) == 0) in_burst = !in_burst;
        if (in_gap > 0 && !in_burst) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          nxt = frame_bytes.pop_front();
          data_byte <= nxt.data;
          last_byte <= nxt.fin;
          in_valid  <= 1'b1;
          in_gap    <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and stall generator.
  always @(posedge clk) begin
    cpd_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output request, kind %0d", $time, item_kind);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("item_kind", 32'(want.item_kind), 32'(item_kind));
          check_field("body_byte", 32'(want.body_byte), 32'(body_byte));
          check_field("body_index", 32'(want.body_index), 32'(body_index));
          check_field("frame_id", want.frame_id, frame_id);
          check_field("packet_type", 32'(want.packet_type), 32'(packet_type));
          check_field("sequence_number", 32'(want.sequence_number),
                      32'(sequence_number));
          check_field("body_length", 32'(want.body_length), 32'(body_length));
          check_field("frame_status", 32'(want.frame_status), 32'(frame_status));
        end
      end
      if ($urandom_range(199) == 0) out_burst = !out_burst;
      if (out_hold > 0 && !out_burst) begin
        out_hold  <= out_hold - 1;
        out_stall <= 1'b1;
      end else begin
        out_hold  <= pick_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("crc8_packet_deframer test failed");
      $finish;
    end
  end

  initial begin
    int r;
    int nframe;
    // directed: lone CRC byte, ID-only short frame, empty body, bad CRC
    add_frame(0, 0, 1'b0, 'hFF);
    add_frame(4, 0, 1'b0, 'hFF);
    add_frame(5, 0, 1'b0, 'hFF);
    add_frame(5, 2, 1'b1, 'h00);

    // random frames; a few fixed slots guarantee the body-limit cases
    nframe = 0;
    while (frame_bytes.size() < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (nframe == 4) add_frame(5, BODY_LIMIT, 1'b0, -1);
      else if (nframe == 7) add_frame(5, BODY_LIMIT + $urandom_range(1, 4), 1'b0, -1);
      else if (nframe == 11) add_frame(5, 130, 1'($urandom_range(1)), -1);
      else if (r < 6) add_frame($urandom_range(0, 4), 0, 1'($urandom_range(1)), -1);
      else if (r < 70) add_frame(5, $urandom_range(0, 10), $urandom_range(9) == 0, -1);
      else if (r < 88) add_frame(5, $urandom_range(11, 63), $urandom_range(9) == 0, -1);
      else if (r < 97) add_frame(5, $urandom_range(64, 72), $urandom_range(3) == 0, -1);
      else add_frame(5, $urandom_range(100, 140), $urandom_range(3) == 0, -1);
      nframe++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // all requests accepted, then all results back, then a short tail;
    // checked between edges so the driver and monitor have settled
    while (frame_bytes.size() > 0 || in_valid) @(negedge clk);
    while (expected_q.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("crc8_packet_deframer test passed");
    end else begin
      $display("crc8_packet_deframer test failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/cpd_pkg.sv
hw/rtl/cpd_in_stage.sv
hw/rtl/cpd_frame_core.sv
hw/rtl/cpd_out_stage.sv
hw/rtl/crc8_packet_deframer.sv
hw/rtl/cpd_checker.sv
bench/testbench.sv
